// ===== hw/rtl/rslh_pkg.sv =====
`default_nettype none

package rslh_pkg;

    // Histogram geometry.
    localparam int NUM_BINS = 64;
    localparam int BIN_AW   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    // Field widths.
    localparam int SAMPLE_W = 32;
    localparam int TOTAL_W  = 64;
    localparam int SCALE_W  = 16;
    localparam int SEL_W    = 6;
    localparam int PROD_W   = SAMPLE_W + SCALE_W;
    localparam int CMP_W    = (BIN_AW > SEL_W) ? BIN_AW : SEL_W;

    // Commands.
    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // Bin for a scaled sample: ceil(log2(p)), zero when p is at most one,
    // clamped to the top bin. The bit length of p-1 gives the ceiling.
    function automatic logic [SEL_W-1:0] pick_bin(input logic [PROD_W-1:0] p);
        logic [PROD_W-1:0] v;
        logic [SEL_W-1:0]  len;
        v   = p - PROD_W'(1);
        len = '0;
        for (int i = 0; i < PROD_W; i++) begin
            if (v[i]) begin
                len = SEL_W'(i + 1);
            end
        end
        if (p <= PROD_W'(1)) begin
            len = '0;
        end
        if (int'(len) > NUM_BINS - 1) begin
            len = SEL_W'(NUM_BINS - 1);
        end
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/running_stats_log2_histogram.sv =====
// An item passes through the input register, the multiplier register, the histogram
// read register and the result register before its result appears.
// Throughput: one item per cycle while the output is not stalled; the histogram
// read-modify-write is forwarded between neighbouring items, so back-to-back
// samples to the same bin are counted. Reset (synchronous, active low) clears the
// statistics, the bin valid bits and the pipeline, and sets the scale factor to one.
`default_nettype none

module running_stats_log2_histogram (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [rslh_pkg::SCALE_W-1:0]   i_cfg_wdata,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic                           i_command,
    input  wire logic [rslh_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire logic [rslh_pkg::SEL_W-1:0]     i_bin_select,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [rslh_pkg::SAMPLE_W-1:0]       o_sample_count,
    output logic [rslh_pkg::TOTAL_W-1:0]        o_total,
    output logic [rslh_pkg::SAMPLE_W-1:0]       o_minimum,
    output logic [rslh_pkg::SAMPLE_W-1:0]       o_maximum,
    output logic [rslh_pkg::SEL_W-1:0]          o_bin_number,
    output logic [rslh_pkg::SAMPLE_W-1:0]       o_bin_count
);

    localparam int SW = rslh_pkg::SAMPLE_W;
    localparam int TW = rslh_pkg::TOTAL_W;
    localparam int AW = rslh_pkg::BIN_AW;
    localparam int NB = rslh_pkg::NUM_BINS;
    localparam int SLW = rslh_pkg::SEL_W;
    localparam int PW = rslh_pkg::PROD_W;
    localparam int CW = rslh_pkg::CMP_W;

    // Configuration register.
    logic [rslh_pkg::SCALE_W-1:0] r_scale;

    // Stage 1: input register.
    logic           r_s1_valid;
    logic           r_s1_cmd;
    logic [SW-1:0]  r_s1_sample;
    logic [SLW-1:0] r_s1_sel;

    // Stage 2: scaled sample.
    logic           r_s2_valid;
    logic           r_s2_cmd;
    logic [SW-1:0]  r_s2_sample;
    logic [SLW-1:0] r_s2_sel;
    logic [PW-1:0]  r_s2_prod;

    // Stage 3: histogram read data.
    logic           r_s3_valid;
    logic           r_s3_cmd;
    logic [SW-1:0]  r_s3_sample;
    logic [SLW-1:0] r_s3_bin;
    logic [AW-1:0]  r_s3_addr;
    logic [SW-1:0]  r_s3_rd;

    // Running statistics.
    logic [SW-1:0] r_count;
    logic [TW-1:0] r_total;
    logic [SW-1:0] r_min;
    logic [SW-1:0] r_max;

    // Histogram memory and its per-bin valid bits.
    logic [SW-1:0] r_hist [NB];
    logic [NB-1:0] r_hist_vld;

    // Result register.
    logic           r_out_valid;
    logic [SW-1:0]  r_out_count;
    logic [TW-1:0]  r_out_total;
    logic [SW-1:0]  r_out_min;
    logic [SW-1:0]  r_out_max;
    logic [SLW-1:0] r_out_bin;
    logic [SW-1:0]  r_out_bin_count;

    // Pipeline advance: a stage loads when it is empty or its occupant moves on.
    logic en1, en2, en3, en_out;
    assign en_out  = r_s3_valid && (!r_out_valid || !i_stall);
    assign en3     = r_s2_valid && (!r_s3_valid || en_out);
    assign en2     = r_s1_valid && (!r_s2_valid || en3);
    assign o_stall = r_s1_valid && !en2;
    assign en1     = i_valid && !o_stall;

    // Multiplier between stage 1 and stage 2.
    logic [PW-1:0] n_prod;
    assign n_prod = PW'(r_s1_sample) * PW'(r_scale);

    // Bin selection in stage 2. The range check is one bit wider than the
    // select so that the bin count itself is representable.
    logic [SLW-1:0] n_bin;
    logic [AW-1:0]  n_addr;
    logic           n_in_range;
    always_comb begin
        if (r_s2_cmd == rslh_pkg::CMD_RECORD) begin
            n_bin      = rslh_pkg::pick_bin(r_s2_prod);
            n_in_range = 1'b1;
        end else begin
            n_bin      = r_s2_sel;
            n_in_range = (CW + 1)'(r_s2_sel) < (CW + 1)'(NB);
        end
        n_addr = AW'(n_bin);
    end

    // Stage 3 arithmetic: statistics and the bin increment.
    logic          wr_en;
    logic          first;
    logic [SW-1:0] min_base, max_base;
    logic [TW:0]   sum;
    logic [SW-1:0] n_count, n_min, n_max, n_bin_count;
    logic [TW-1:0] n_total;
    always_comb begin
        first    = (r_count == '0);
        min_base = first ? r_s3_sample : r_min;
        max_base = first ? r_s3_sample : r_max;
        sum      = {1'b0, r_total} + (TW + 1)'(r_s3_sample);
        n_count  = r_count;
        n_total  = r_total;
        n_min    = r_min;
        n_max    = r_max;
        n_bin_count = r_s3_rd;
        if (r_s3_cmd == rslh_pkg::CMD_RECORD) begin
            n_count = (r_count == '1) ? r_count : r_count + SW'(1);
            n_total = sum[TW] ? '1 : sum[TW-1:0];
            n_min   = (r_s3_sample < min_base) ? r_s3_sample : min_base;
            n_max   = (r_s3_sample > max_base) ? r_s3_sample : max_base;
            n_bin_count = (r_s3_rd == '1) ? r_s3_rd : r_s3_rd + SW'(1);
        end
    end
    assign wr_en = en_out && (r_s3_cmd == rslh_pkg::CMD_RECORD);

    // Configuration write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= rslh_pkg::SCALE_W'(1);
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_wdata;
        end
    end

    // Pipeline valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1) begin
                r_s1_valid <= 1'b1;
            end else if (en2) begin
                r_s1_valid <= 1'b0;
            end
            if (en2) begin
                r_s2_valid <= 1'b1;
            end else if (en3) begin
                r_s2_valid <= 1'b0;
            end
            if (en3) begin
                r_s3_valid <= 1'b1;
            end else if (en_out) begin
                r_s3_valid <= 1'b0;
            end
            if (en_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_cmd    <= i_command;
            r_s1_sample <= i_sample;
            r_s1_sel    <= i_bin_select;
        end
        if (en2) begin
            r_s2_cmd    <= r_s1_cmd;
            r_s2_sample <= r_s1_sample;
            r_s2_sel    <= r_s1_sel;
            r_s2_prod   <= n_prod;
        end
        if (en3) begin
            r_s3_cmd    <= r_s2_cmd;
            r_s3_sample <= r_s2_sample;
            r_s3_bin    <= n_bin;
            r_s3_addr   <= n_addr;
        end
        if (en_out) begin
            r_out_count     <= n_count;
            r_out_total     <= n_total;
            r_out_min       <= n_min;
            r_out_max       <= n_max;
            r_out_bin       <= r_s3_bin;
            r_out_bin_count <= n_bin_count;
        end
    end

    // Histogram read with registered data. A write to the same bin in the
    // same cycle is forwarded; an unwritten or out-of-range bin reads as zero.
    always_ff @(posedge i_clk) begin
        if (en3) begin
            if (wr_en && (r_s3_addr == n_addr) && n_in_range) begin
                r_s3_rd <= n_bin_count;
            end else if (n_in_range && r_hist_vld[n_addr]) begin
                r_s3_rd <= r_hist[n_addr];
            end else begin
                r_s3_rd <= '0;
            end
        end
    end

    // Histogram write.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_hist[r_s3_addr] <= n_bin_count;
        end
    end

    // Bin valid bits, cleared at reset so every bin starts at zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_vld <= '0;
        end else if (wr_en) begin
            r_hist_vld[r_s3_addr] <= 1'b1;
        end
    end

    // Statistics update as each item leaves stage 3.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
            r_min   <= '0;
            r_max   <= '0;
        end else if (en_out) begin
            r_count <= n_count;
            r_total <= n_total;
            r_min   <= n_min;
            r_max   <= n_max;
        end
    end

    // Outputs.
    assign o_valid        = r_out_valid;
    assign o_sample_count = r_out_count;
    assign o_total        = r_out_total;
    assign o_minimum      = r_out_min;
    assign o_maximum      = r_out_max;
    assign o_bin_number   = r_out_bin;
    assign o_bin_count    = r_out_bin_count;

    // The sample count never goes backwards.
    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count >= $past(r_count))
        else $error("sample count decreased");

    // Once a sample is recorded, the minimum never exceeds the maximum.
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> r_min <= r_max)
        else $error("minimum above maximum");

    // The total covers at least the largest sample.
    a_total_ge_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> r_total >= TW'(r_max))
        else $error("total below maximum");

endmodule

`default_nettype wire
